FILE: rtl/qwt_pkg.sv
package qwt_pkg;

  localparam int MAX_WORD = 256;
  // longest word kept, whatever the buffer size
  localparam int WORD_CAP = ((MAX_WORD - 1) > 255) ? 255 : (MAX_WORD - 1);

  localparam logic [8:0] BUF_SIZE_RESET = 9'd256;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_LEAD  = 4'b0010,
    PH_WORD  = 4'b0100,
    PH_TRAIL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       last;
    kind_t      kind;
    logic [7:0] ch;
    logic [7:0] len;
    logic       eol;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic       sq;
    logic       dq;
    logic [7:0] cnt;
    logic       emit;
    result_t    res;
  } word_step_t;

  // one item seen from inside a word
  function automatic word_step_t word_item(logic [7:0] c, logic eof, logic sq, logic dq,
                                           logic [7:0] cnt, logic [7:0] limit);
    word_step_t w;
    logic add;
    w       = '0;
    w.phase = PH_WORD;
    w.sq    = sq;
    w.dq    = dq;
    w.cnt   = cnt;
    w.res.kind = KIND_CHAR;
    add     = 1'b0;
    if (eof) begin
      w.emit     = 1'b1;
      w.res.kind = KIND_END;
      w.res.len  = cnt;
      w.res.eol  = 1'b1;
      w.cnt      = 8'd0;
      w.sq       = 1'b0;
      w.dq       = 1'b0;
      w.phase    = PH_START;
    end else if (c == CH_SQUOTE) begin
      if (!dq) w.sq = !sq;
      else add = 1'b1;
    end else if (c == CH_DQUOTE) begin
      if (!sq) w.dq = !dq;
      else add = 1'b1;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      if (sq || dq) begin
        add = 1'b1;
      end else if (c == CH_NL) begin
        w.emit     = 1'b1;
        w.res.kind = KIND_END;
        w.res.len  = cnt;
        w.res.eol  = 1'b1;
        w.cnt      = 8'd0;
        w.sq       = 1'b0;
        w.dq       = 1'b0;
        w.phase    = PH_START;
      end else begin
        w.phase = PH_TRAIL;
      end
    end else begin
      add = 1'b1;
    end
    if (add && (cnt < limit)) begin
      w.emit     = 1'b1;
      w.res.kind = KIND_CHAR;
      w.res.ch   = c;
      w.cnt      = cnt + 8'd1;
    end
    return w;
  endfunction

endpackage

FILE: rtl/quoted_word_tokenizer.sv
// Quoted word tokenizer: takes one character request per cycle while in_tready is high
// (tuser marks end of input), updates the tokenizer state in the same cycle and pushes
// zero, one or two results into a four-entry result queue that drives the output stream.
// Two results (a new word right after trailing blanks) are pushed at once; results leave
// at one per cycle while out_tready is high; in_tready drops once the queue holds three or
// more results. buffer_size is to be written through cfg_* while the block is idle, which
// the block does not enforce; words keep at most buffer_size-1 characters, capped at 255.
module quoted_word_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tuser,   // at_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_char, word_length, at_eol, zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // buffer_size
);

  qwt_pkg::phase_t phase_r, phase_nxt;
  logic            sq_r, sq_nxt;
  logic            dq_r, dq_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [8:0]      buf_size_r;

  qwt_pkg::result_t q_mem [4];
  logic [1:0]       wr_ptr_r, rd_ptr_r;
  logic [2:0]       count_r;

  logic             in_acc, out_acc;
  logic [7:0]       limit;
  logic [8:0]       lim9;
  logic             blank;
  logic             e0_v, e1_v;
  qwt_pkg::result_t e0, e1;
  qwt_pkg::word_step_t ws;
  logic [2:0]       n_push;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign in_tready = (count_r <= 3'd2);
  assign cfg_ready = 1'b1;

  assign lim9  = buf_size_r - 9'd1;
  always_comb begin
    if (buf_size_r == 9'd0) limit = 8'd0;
    else if (lim9 > 9'(qwt_pkg::WORD_CAP)) limit = 8'(qwt_pkg::WORD_CAP);
    else limit = lim9[7:0];
  end

  assign blank = !in_tuser && (in_tdata == qwt_pkg::CH_SPACE || in_tdata == qwt_pkg::CH_TAB);

  always_comb begin
    phase_nxt = phase_r;
    sq_nxt    = sq_r;
    dq_nxt    = dq_r;
    cnt_nxt   = cnt_r;
    e0_v      = 1'b0;
    e1_v      = 1'b0;
    e0        = '0;
    e1        = '0;
    ws        = qwt_pkg::word_item(in_tdata, in_tuser, sq_r, dq_r, cnt_r, limit);
    case (phase_r)
      qwt_pkg::PH_START: begin
        if (in_tuser) begin
          e0_v      = 1'b1;
          e0.kind   = qwt_pkg::KIND_NONE;
        end else if (blank) begin
          phase_nxt = qwt_pkg::PH_LEAD;
        end else begin
          phase_nxt = ws.phase;
          sq_nxt    = ws.sq;
          dq_nxt    = ws.dq;
          cnt_nxt   = ws.cnt;
          e0_v      = ws.emit;
          e0        = ws.res;
        end
      end
      qwt_pkg::PH_LEAD, qwt_pkg::PH_WORD: begin
        if (!blank || phase_r == qwt_pkg::PH_WORD) begin
          phase_nxt = ws.phase;
          sq_nxt    = ws.sq;
          dq_nxt    = ws.dq;
          cnt_nxt   = ws.cnt;
          e0_v      = ws.emit;
          e0        = ws.res;
        end
      end
      qwt_pkg::PH_TRAIL: begin
        if (!blank) begin
          e0_v    = 1'b1;
          e0.kind = qwt_pkg::KIND_END;
          e0.len  = cnt_r;
          if (in_tuser || in_tdata == qwt_pkg::CH_NL) begin
            e0.eol    = 1'b1;
            phase_nxt = qwt_pkg::PH_START;
            sq_nxt    = 1'b0;
            dq_nxt    = 1'b0;
            cnt_nxt   = 8'd0;
          end else begin
            // previous word closes, the new one starts from clean state
            ws        = qwt_pkg::word_item(in_tdata, 1'b0, 1'b0, 1'b0, 8'd0, limit);
            phase_nxt = ws.phase;
            sq_nxt    = ws.sq;
            dq_nxt    = ws.dq;
            cnt_nxt   = ws.cnt;
            e1_v      = ws.emit;
            e1        = ws.res;
          end
        end
      end
      default: begin
        phase_nxt = qwt_pkg::PH_START;
      end
    endcase
    if (e1_v) e1.last = 1'b1;
    else e0.last = 1'b1;
  end

  assign n_push = in_acc ? (3'(e0_v) + 3'(e1_v)) : 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= qwt_pkg::PH_START;
      sq_r       <= 1'b0;
      dq_r       <= 1'b0;
      cnt_r      <= 8'd0;
      buf_size_r <= qwt_pkg::BUF_SIZE_RESET;
      wr_ptr_r   <= 2'd0;
      rd_ptr_r   <= 2'd0;
      count_r    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) buf_size_r <= cfg_data;
      if (in_acc) begin
        phase_r <= phase_nxt;
        sq_r    <= sq_nxt;
        dq_r    <= dq_nxt;
        cnt_r   <= cnt_nxt;
      end
      wr_ptr_r <= wr_ptr_r + n_push[1:0];
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r  <= count_r + n_push - 3'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && e0_v) q_mem[wr_ptr_r] <= e0;
    if (in_acc && e1_v) q_mem[wr_ptr_r + 2'd1] <= e1;
  end

  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = {7'd0, q_mem[rd_ptr_r].eol, q_mem[rd_ptr_r].len, q_mem[rd_ptr_r].ch};
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last;

  // queue never overfills
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 3'd4)
    else $error("result queue overflow");

  // idle between words means no quoting and no kept characters
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == qwt_pkg::PH_START || phase_r == qwt_pkg::PH_LEAD) |->
      (!sq_r && !dq_r && cnt_r == 8'd0))
    else $error("stale word state outside a word");

  // end of input always returns to start
  a_eof_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser) |=> (phase_r == qwt_pkg::PH_START))
    else $error("end of input did not return to start");

  // every request that hits a blank at start produces nothing and moves to lead
  a_lead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && blank && phase_r == qwt_pkg::PH_START) |-> (n_push == 3'd0))
    else $error("leading blank produced a result");

endmodule

FILE: tb/tb_quoted_word_tokenizer.sv
`timescale 1ns / 1ps

module tb_quoted_word_tokenizer;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_PER_SETTING = 180;
  localparam int LONG_WORD_LEN = 270;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // in_byte
  logic        in_tuser = 1'b0;   // at_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // out_char, word_length, at_eol, zero pad
  logic [1:0]  out_tuser;         // kind
  logic        out_tlast;         // last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = 9'd0;   // buffer_size

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int settings_used = 0;

  typedef struct {
    qwt_pkg::kind_t kind;
    logic [7:0]     ch;
    logic [7:0]     len;
    logic           eol;
    logic           last;
  } token_t;

  class token_scoreboard;
    token_t          pending[$];
    qwt_pkg::phase_t ph;
    bit              in_squote;
    bit              in_dquote;
    bit [7:0]        kept;
    bit [8:0]        buf_size;
    int              errors;
    int              checked;

    function void reset_state();
      ph        = qwt_pkg::PH_START;
      in_squote = 1'b0;
      in_dquote = 1'b0;
      kept      = 8'd0;
      buf_size  = qwt_pkg::BUF_SIZE_RESET;
    endfunction

    function void set_buffer_size(bit [8:0] v);
      buf_size = v;
    endfunction

    function int keep_limit();
      int lim;
      lim = (buf_size == 9'd0) ? 0 : int'(buf_size) - 1;
      if (lim > qwt_pkg::WORD_CAP) lim = qwt_pkg::WORD_CAP;
      if (lim > 255) lim = 255;
      return lim;
    endfunction

    function void push(qwt_pkg::kind_t k, logic [7:0] c, logic [7:0] n, logic e);
      token_t t;
      t.kind = k;
      t.ch   = c;
      t.len  = n;
      t.eol  = e;
      t.last = 1'b0;
      pending.push_back(t);
    endfunction

    function void close_word(logic e);
      push(qwt_pkg::KIND_END, 8'd0, kept, e);
      kept      = 8'd0;
      in_squote = 1'b0;
      in_dquote = 1'b0;
    endfunction

    function void word_char(logic [7:0] c, logic eof);
      bit keep;
      keep = 1'b0;
      ph   = qwt_pkg::PH_WORD;
      if (eof) begin
        close_word(1'b1);
        ph = qwt_pkg::PH_START;
        return;
      end
      if (c == qwt_pkg::CH_SQUOTE) begin
        if (!in_dquote) in_squote = !in_squote;
        else keep = 1'b1;
      end else if (c == qwt_pkg::CH_DQUOTE) begin
        if (!in_squote) in_dquote = !in_dquote;
        else keep = 1'b1;
      end else if (c == qwt_pkg::CH_SPACE || c == qwt_pkg::CH_TAB || c == qwt_pkg::CH_NL) begin
        if (in_squote || in_dquote) begin
          keep = 1'b1;
        end else if (c == qwt_pkg::CH_NL) begin
          close_word(1'b1);
          ph = qwt_pkg::PH_START;
        end else begin
          ph = qwt_pkg::PH_TRAIL;
        end
      end else begin
        keep = 1'b1;
      end
      if (keep && int'(kept) < keep_limit()) begin
        push(qwt_pkg::KIND_CHAR, c, 8'd0, 1'b0);
        kept++;
      end
    endfunction

    function void note_request(logic [7:0] c, logic eof);
      int  prior;
      bit  blank;
      prior = pending.size();
      blank = !eof && (c == qwt_pkg::CH_SPACE || c == qwt_pkg::CH_TAB);
      case (ph)
        qwt_pkg::PH_START: begin
          if (eof) push(qwt_pkg::KIND_NONE, 8'd0, 8'd0, 1'b0);
          else if (blank) ph = qwt_pkg::PH_LEAD;
          else word_char(c, 1'b0);
        end
        qwt_pkg::PH_LEAD: begin
          if (!blank) word_char(c, eof);
        end
        qwt_pkg::PH_WORD: begin
          word_char(c, eof);
        end
        default: begin
          if (!blank) begin
            if (eof || c == qwt_pkg::CH_NL) begin
              close_word(1'b1);
              ph = qwt_pkg::PH_START;
            end else begin
              // next word begins right after the trailing blanks
              close_word(1'b0);
              word_char(c, 1'b0);
            end
          end
        end
      endcase
      if (pending.size() > prior) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [1:0] k, logic [23:0] d, logic l);
      token_t t;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none pending: kind %0d char %02h len %0d eol %0b last %0b",
                   $realtime, k, d[7:0], d[15:8], d[16], l);
        return;
      end
      t = pending.pop_front();
      if (k !== t.kind || d[7:0] !== t.ch || d[15:8] !== t.len || d[16] !== t.eol ||
          l !== t.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp kind %0d char %02h len %0d eol %0b last %0b",
                   $realtime, t.kind, t.ch, t.len, t.eol, t.last);
          $display("%0t: mismatch got kind %0d char %02h len %0d eol %0b last %0b",
                   $realtime, k, d[7:0], d[15:8], d[16], l);
        end
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        $display("%0d results never arrived", pending.size());
        errors += pending.size();
        pending.delete();
      end
    endfunction
  endclass

  token_scoreboard sb = new();

  quoted_word_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // requests noted before results so a same-edge pass-through still lines up
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_request(logic [7:0] c, logic eof);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eof;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic write_buffer_size(logic [8:0] v);
    in_tvalid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a blank or dropped character may still be in flight with no result
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_buffer_size(v);
    settings_used++;
  endtask

  task automatic pick_request(output logic [7:0] c, output logic eof);
    int r;
    r   = $urandom_range(99);
    eof = 1'b0;
    c   = CH_LOWER_A + 8'($urandom_range(25));
    if (r < 12) c = qwt_pkg::CH_SPACE;
    else if (r < 17) c = qwt_pkg::CH_TAB;
    else if (r < 24) c = qwt_pkg::CH_NL;
    else if (r < 30) c = qwt_pkg::CH_SQUOTE;
    else if (r < 36) c = qwt_pkg::CH_DQUOTE;
    else if (r < 46) c = 8'($urandom_range(255));
    else if (r < 50) begin
      eof = 1'b1;
      c   = 8'($urandom_range(255));
    end
  endtask

  task automatic send_long_word(int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(3) == 0) ? 8'($urandom_range(128, 255))
                                   : CH_LOWER_A + 8'($urandom_range(25));
      send_request(c, 1'b0);
    end
    send_request(qwt_pkg::CH_NL, 1'b0);
  endtask

  task automatic run_directed();
    // end of input as the very first request
    send_request(8'h5a, 1'b1);
    // blanks after a word, then the next word starts in the same request
    send_request(CH_LOWER_A, 1'b0);
    send_request(CH_LOWER_A + 8'd1, 1'b0);
    send_request(qwt_pkg::CH_SPACE, 1'b0);
    send_request(qwt_pkg::CH_TAB, 1'b0);
    send_request(CH_LOWER_A + 8'd2, 1'b0);
    // quoted blank, single quote kept inside double quotes
    send_request(qwt_pkg::CH_DQUOTE, 1'b0);
    send_request(qwt_pkg::CH_SPACE, 1'b0);
    send_request(qwt_pkg::CH_SQUOTE, 1'b0);
    send_request(qwt_pkg::CH_DQUOTE, 1'b0);
    send_request(qwt_pkg::CH_NL, 1'b0);
    // empty words: blanks then end, blanks then newline
    send_request(qwt_pkg::CH_SPACE, 1'b0);
    send_request(8'h00, 1'b1);
    send_request(qwt_pkg::CH_TAB, 1'b0);
    send_request(qwt_pkg::CH_NL, 1'b0);
    // quote left open at end of input, newline and double quote kept
    send_request(qwt_pkg::CH_SQUOTE, 1'b0);
    send_request(qwt_pkg::CH_NL, 1'b0);
    send_request(qwt_pkg::CH_DQUOTE, 1'b0);
    send_request(8'hff, 1'b1);
    // trailing blanks then end, extreme byte values
    send_request(8'hff, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(qwt_pkg::CH_SPACE, 1'b0);
    send_request(8'ha5, 1'b1);
  endtask

  initial begin
    logic [8:0] sizes[6];
    logic [7:0] c;
    logic       eof;
    sizes = '{9'd256, 9'd1, 9'd0, 9'd3, 9'd200, 9'd256};
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct   = 6;
    out_stall_pct = 6;
    run_directed();

    for (int p = 0; p < 6; p++) begin
      write_buffer_size(sizes[p]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 6; out_stall_pct = 6; end
      endcase
      for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
        if (i == RANDOM_PER_SETTING / 2 && sizes[p] >= 9'd200) send_long_word(LONG_WORD_LEN);
        pick_request(c, eof);
        send_request(c, eof);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();

    $display("summary: %0d requests, %0d results checked, %0d buffer size writes",
             requests_sent, sb.checked, settings_used);
    $display("summary: flow control with no gaps, sender gaps, receiver stalls and both");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d errors", sb.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
